// ===== rtl/smsort_pkg.sv =====
// Shared constants and types for the stable mask sorter.
package smsort_pkg;

  // Default sizes
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_DIMS_DEF   = 64;

  // Fixed field widths
  localparam int MASK_W  = 64;
  localparam int IDX_W   = 6;
  localparam int NDIM_W  = 7;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Register indexes
  localparam logic REG_NUM_DIMS = 1'b0;

  // Reset value of the dimension count
  localparam logic [NDIM_W-1:0] NUM_DIMS_RST = 7'd64;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the broadcast point
    logic drn;  // shift one place towards the head
  } cell_ctrl_t;

endpackage

// ===== rtl/stable_mask_sort_change_flags_top.sv =====
// Top level: stable mask sorter with run-boundary flags, APB register port.
// Throughput: one point accepted per cycle while a set is being loaded.
// Output: the first result is offered the cycle after the closing point's transfer;
// the stored points then drain one result per cycle while out_ready is high, set by the chain shift.
// Input is not taken while a set drains.
// Reset (synchronous, rst_n low) empties the chain, clears count and overflow, num_dims = 64.
module stable_mask_sort_change_flags_top
  import smsort_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_DIMS   = MAX_DIMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // point input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MASK_W-1:0] in_mask_bits,
  input  logic              in_last_point,
  // sorted results
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_point_index,
  output logic              out_mask_changed,
  output logic              out_overflow,
  output logic              out_last_result,
  // register port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_POINTS);
  localparam logic [NDIM_W-1:0] DIMS_MAX = NDIM_W'(MAX_DIMS);

  logic [NDIM_W-1:0]   num_dims_r;
  logic [CNT_W-1:0]    count_r;
  logic                ovf_r;
  logic                drain_r;
  logic                first_r;
  logic [MAX_DIMS-1:0] prev_mask_r;

  logic [NDIM_W-1:0]   dims_sat;
  logic [MAX_DIMS-1:0] in_mask_cut;
  logic                in_xfer, out_xfer, cfg_wr;
  cell_ctrl_t          ctrl;
  logic                head_valid, second_valid;
  logic [MAX_DIMS-1:0] head_mask;
  logic [IDX_W-1:0]    head_idx;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_NUM_DIMS) ? APB_DW'(num_dims_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= NUM_DIMS_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_NUM_DIMS) begin
      num_dims_r <= cfg_pwdata[NDIM_W-1:0];
    end
  end

  // Clear dimensions at and above the saturated count; dimension 0 is the MSB
  assign dims_sat = (num_dims_r > DIMS_MAX) ? DIMS_MAX : num_dims_r;

  always_comb begin
    for (int b = 0; b < MAX_DIMS; b++) begin
      in_mask_cut[b] = in_mask_bits[MASK_W-MAX_DIMS+b] &&
                       (NDIM_W'(MAX_DIMS - 1 - b) < dims_sat);
    end
  end

  // Handshakes
  assign in_ready  = !drain_r;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = drain_r;
  assign out_xfer  = out_valid && out_ready;

  assign ctrl.ins = in_xfer && (count_r < CNT_MAX);
  assign ctrl.drn = out_xfer;

  smsort_chain #(
    .MAX_POINTS (MAX_POINTS),
    .MW         (MAX_DIMS)
  ) u_chain (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .new_mask     (in_mask_cut),
    .new_idx      (IDX_W'(count_r)),
    .head_valid   (head_valid),
    .head_mask    (head_mask),
    .head_idx     (head_idx),
    .second_valid (second_valid)
  );

  // Result fields from the head cell; last flag from the second cell, overflow from the set state
  assign out_point_index  = head_idx;
  assign out_mask_changed = first_r || (head_mask != prev_mask_r);
  assign out_overflow     = ovf_r;
  assign out_last_result  = !second_valid;

  // Set control: count, overflow, drain phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      drain_r <= 1'b0;
      first_r <= 1'b1;
    end else if (out_xfer) begin
      first_r <= out_last_result;
      if (out_last_result) begin
        drain_r <= 1'b0;
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
    end else if (in_xfer) begin
      if (count_r < CNT_MAX) begin
        count_r <= count_r + 1'b1;
      end else begin
        ovf_r <= 1'b1;
      end
      if (in_last_point) begin
        drain_r <= 1'b1;
      end
    end
  end

  // Hold the mask of the last transferred result
  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_mask_r <= head_mask;
    end
  end

  // Checks
  a_head_filled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> head_valid)
    else $error("result offered from an empty head cell");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a set drains");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("point count beyond capacity");

  a_drain_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !out_last_result) |=> out_valid)
    else $error("drain stopped before the final result");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last_result) |=> (count_r == '0 && !ovf_r && !head_valid))
    else $error("store not emptied after the final result");

endmodule

// ===== rtl/smsort_cell.sv =====
// One cell of the insertion chain: holds one sorted entry.
module smsort_cell
  import smsort_pkg::*;
#(
  parameter int MW = MAX_DIMS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  logic [MW-1:0]    new_mask,
  input  logic [IDX_W-1:0] new_idx,
  input  logic             prev_keep,
  input  logic             prev_valid,
  input  logic [MW-1:0]    prev_mask,
  input  logic [IDX_W-1:0] prev_idx,
  input  logic             next_valid,
  input  logic [MW-1:0]    next_mask,
  input  logic [IDX_W-1:0] next_idx,
  output logic             keep,
  output logic             valid,
  output logic [MW-1:0]    mask,
  output logic [IDX_W-1:0] idx
);

  logic             valid_r, valid_nxt;
  logic [MW-1:0]    mask_r, mask_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Entry stays put when it is not above the new mask (equal keeps arrival order)
  assign keep = valid_r && (mask_r <= new_mask);

  // Select hold, take new point, take left neighbour or take right neighbour
  always_comb begin
    valid_nxt = valid_r;
    mask_nxt  = mask_r;
    idx_nxt   = idx_r;
    if (ctrl.drn) begin
      valid_nxt = next_valid;
      mask_nxt  = next_mask;
      idx_nxt   = next_idx;
    end else if (ctrl.ins && !keep) begin
      if (prev_keep) begin
        valid_nxt = 1'b1;
        mask_nxt  = new_mask;
        idx_nxt   = new_idx;
      end else begin
        valid_nxt = prev_valid;
        mask_nxt  = prev_mask;
        idx_nxt   = prev_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    idx_r  <= idx_nxt;
  end

  assign valid = valid_r;
  assign mask  = mask_r;
  assign idx   = idx_r;

endmodule

// ===== rtl/smsort_chain.sv =====
// Row of sorting cells, head at cell 0 holding the smallest mask.
module smsort_chain
  import smsort_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MW         = MAX_DIMS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  logic [MW-1:0]    new_mask,
  input  logic [IDX_W-1:0] new_idx,
  output logic             head_valid,
  output logic [MW-1:0]    head_mask,
  output logic [IDX_W-1:0] head_idx,
  output logic             second_valid
);

  logic             keep_w  [MAX_POINTS];
  logic             valid_w [MAX_POINTS+1];
  logic [MW-1:0]    mask_w  [MAX_POINTS+1];
  logic [IDX_W-1:0] idx_w   [MAX_POINTS+1];

  // Empty slot beyond the tail feeds the last cell while draining
  assign valid_w[MAX_POINTS] = 1'b0;
  assign mask_w[MAX_POINTS]  = '0;
  assign idx_w[MAX_POINTS]   = '0;

  generate
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      logic             pk;
      logic             pv;
      logic [MW-1:0]    pm;
      logic [IDX_W-1:0] pi;
      if (i == 0) begin : g_head
        // Head has nothing to its left: take the new point when not kept
        assign pk = 1'b1;
        assign pv = 1'b0;
        assign pm = '0;
        assign pi = '0;
      end else begin : g_body
        assign pk = keep_w[i-1];
        assign pv = valid_w[i-1];
        assign pm = mask_w[i-1];
        assign pi = idx_w[i-1];
      end
      smsort_cell #(
        .MW (MW)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_mask   (new_mask),
        .new_idx    (new_idx),
        .prev_keep  (pk),
        .prev_valid (pv),
        .prev_mask  (pm),
        .prev_idx   (pi),
        .next_valid (valid_w[i+1]),
        .next_mask  (mask_w[i+1]),
        .next_idx   (idx_w[i+1]),
        .keep       (keep_w[i]),
        .valid      (valid_w[i]),
        .mask       (mask_w[i]),
        .idx        (idx_w[i])
      );
    end
  endgenerate

  assign head_valid   = valid_w[0];
  assign head_mask    = mask_w[0];
  assign head_idx     = idx_w[0];
  assign second_valid = valid_w[1];

endmodule
